// ===== src/blg_pkg.sv =====
// Shared types, constants and helper functions of the boosting loss unit.
package blg_pkg;

  localparam int FracBitsDef = 16;

  localparam int InW   = 27;
  localparam int LossW = 40;
  localparam int GradW = 28;
  localparam int HessW = 17;

  // Series datapath widths (Q.30 values).
  localparam int TermW = 31;
  localparam int OpW   = 30;
  localparam int AccW  = 33;

  // Restoring divider widths.
  localparam int RemW = 62;
  localparam int DenW = 32;
  localparam int QuoW = 31;

  localparam int ExpTerms = 14;
  localparam int LogTerms = 12;

  localparam logic [29:0] Ln2Q30 = 30'd744261118;
  // At or above this argument exp(-a) underflows to zero (k of 40 or more).
  localparam logic [37:0] ZeroLim = 38'(64'd40 * 64'd744261118);
  // floor(2^40 / ln2 in Q.30), for the range reduction quotient.
  localparam logic [10:0] KRecip = 11'((64'd1 << 40) / 64'd744261118);

  typedef struct packed {
    logic              mode;
    logic signed [26:0] label;
    logic signed [26:0] pred;
  } blg_base_t;

  typedef struct packed {
    logic       zero;
    logic [5:0] k;
    blg_base_t  base;
  } blg_exp_side_t;

  typedef struct packed {
    logic [QuoW-1:0] ppos;
    blg_base_t       base;
  } blg_log_side_t;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [DenW-1:0] den;
    logic [QuoW-1:0] quo;
  } blg_div_lane_t;

  // Clamps the margin to plus or minus 250.
  function automatic logic signed [26:0] clamp_z(input logic signed [26:0] pr, input int frac);
    logic signed [35:0] lim;
    logic signed [35:0] p;
    lim = 36'sd250 <<< frac;
    p   = 36'(pr);
    if (p > lim) begin
      p = lim;
    end else if (p < -lim) begin
      p = -lim;
    end
    return p[26:0];
  endfunction

  // Magnitude of the clamped margin, moved to Q.30.
  function automatic logic [37:0] abs_q30(input logic signed [26:0] zc, input int frac);
    logic [26:0] m;
    logic [63:0] w;
    m = zc[26] ? 27'(-zc) : 27'(zc);
    w = 64'(m) << (30 - frac);
    return w[37:0];
  endfunction

endpackage

// ===== src/blg_front.sv =====
// Input register, margin clamp and ln2 range reduction for the exponential.
module blg_front import blg_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  blg_base_t  base_i,
  output logic       valid_o,
  output blg_base_t  base_o,
  output logic       zero_o,
  output logic [5:0] k_o,
  output logic [29:0] r_o
);

  logic        v0_q, v1_q, v2_q;
  blg_base_t   base0_q, base1_q, base2_q;
  logic [45:0] prod1_q;
  logic [34:0] a1_q;
  logic        zero1_q, zero2_q;
  logic [5:0]  k2_q;
  logic [29:0] r2_q;

  logic signed [26:0] zc;
  logic [37:0] a;
  logic [45:0] prod1_d;
  logic [5:0]  k0;
  logic [36:0] r0;
  logic [5:0]  k2_d;
  logic [36:0] r2_d;

  always_comb begin
    zc      = clamp_z(base0_q.pred, FRAC_BITS);
    a       = abs_q30(zc, FRAC_BITS);
    prod1_d = 46'(a[34:0]) * 46'(KRecip);
  end

  // The reciprocal estimate is at most one below the true quotient.
  always_comb begin
    k0 = prod1_q[45:40];
    r0 = 37'(a1_q) - 37'(k0) * 37'(Ln2Q30);
    if (r0 >= 37'(Ln2Q30)) begin
      k2_d = k0 + 6'd1;
      r2_d = r0 - 37'(Ln2Q30);
    end else begin
      k2_d = k0;
      r2_d = r0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    base0_q <= base_i;
    base1_q <= base0_q;
    prod1_q <= prod1_d;
    a1_q    <= a[34:0];
    zero1_q <= (a >= ZeroLim);
    base2_q <= base1_q;
    zero2_q <= zero1_q;
    k2_q    <= k2_d;
    r2_q    <= r2_d[29:0];
  end

  assign valid_o = v2_q;
  assign base_o  = base2_q;
  assign zero_o  = zero2_q;
  assign k_o     = k2_q;
  assign r_o     = r2_q;

endmodule

// ===== src/blg_series_cell.sv =====
// One term of a power series: multiply, divide by a constant, accumulate.
module blg_series_cell import blg_pkg::*; #(
  parameter int DIVISOR   = 1,
  parameter bit CHAIN_DIV = 1'b1,
  parameter bit NEGATE    = 1'b0,
  parameter int SIDE_W    = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [TermW-1:0]       term_i,
  input  logic [OpW-1:0]         op_i,
  input  logic signed [AccW-1:0] acc_i,
  input  logic [SIDE_W-1:0]      side_i,
  output logic                   valid_o,
  output logic [TermW-1:0]       term_o,
  output logic [OpW-1:0]         op_o,
  output logic signed [AccW-1:0] acc_o,
  output logic [SIDE_W-1:0]      side_o
);

  localparam logic [32:0] Recip = 33'((64'd1 << 32) / 64'(DIVISOR));

  logic                   v1_q, v2_q, v3_q;
  logic [60:0]            prod1_q;
  logic [OpW-1:0]         op1_q, op2_q, op3_q;
  logic signed [AccW-1:0] acc1_q, acc2_q, acc3_q;
  logic [SIDE_W-1:0]      side1_q, side2_q, side3_q;
  logic [63:0]            xm2_q;
  logic [TermW-1:0]       x2_q, term3_q;

  logic [TermW-1:0]       x;
  logic [31:0]            q0;
  logic [36:0]            rem;
  logic [TermW-1:0]       q;
  logic [TermW-1:0]       term3_d;
  logic signed [AccW-1:0] acc3_d;

  assign x = prod1_q[60:30];

  // The reciprocal quotient is exact or one low; one compare fixes it.
  always_comb begin
    q0  = xm2_q[63:32];
    rem = 37'(x2_q) - 37'(q0) * 37'(DIVISOR);
    if (rem >= 37'(DIVISOR)) begin
      q = TermW'(q0 + 32'd1);
    end else begin
      q = TermW'(q0);
    end
    term3_d = CHAIN_DIV ? q : x2_q;
    if (NEGATE) begin
      acc3_d = acc2_q - $signed({2'b00, q});
    end else begin
      acc3_d = acc2_q + $signed({2'b00, q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod1_q <= 61'(term_i) * 61'(op_i);
    op1_q   <= op_i;
    acc1_q  <= acc_i;
    side1_q <= side_i;
    xm2_q   <= 64'(x) * 64'(Recip);
    x2_q    <= x;
    op2_q   <= op1_q;
    acc2_q  <= acc1_q;
    side2_q <= side1_q;
    term3_q <= term3_d;
    op3_q   <= op2_q;
    acc3_q  <= acc3_d;
    side3_q <= side2_q;
  end

  assign valid_o = v3_q;
  assign term_o  = term3_q;
  assign op_o    = op3_q;
  assign acc_o   = acc3_q;
  assign side_o  = side3_q;

endmodule

// ===== src/blg_div_cell.sv =====
// One quotient bit of two restoring divisions that run side by side.
module blg_div_cell import blg_pkg::*; #(
  parameter int J      = 0,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  blg_div_lane_t     lane_a_i,
  input  blg_div_lane_t     lane_b_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output blg_div_lane_t     lane_a_o,
  output blg_div_lane_t     lane_b_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              v_q;
  blg_div_lane_t     a_q, b_q;
  logic [SIDE_W-1:0] side_q;
  blg_div_lane_t     a_d, b_d;
  logic [RemW-1:0]   sh_a, sh_b;

  always_comb begin
    a_d  = lane_a_i;
    b_d  = lane_b_i;
    sh_a = RemW'(lane_a_i.den) << J;
    sh_b = RemW'(lane_b_i.den) << J;
    if (lane_a_i.rem >= sh_a) begin
      a_d.rem    = lane_a_i.rem - sh_a;
      a_d.quo[J] = 1'b1;
    end
    if (lane_b_i.rem >= sh_b) begin
      b_d.rem    = lane_b_i.rem - sh_b;
      b_d.quo[J] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    side_q <= side_i;
  end

  assign valid_o  = v_q;
  assign lane_a_o = a_q;
  assign lane_b_o = b_q;
  assign side_o   = side_q;

endmodule

// ===== src/blg_finish.sv =====
// Final products, rounding, mode select and saturation of the three results.
module blg_finish import blg_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic signed [AccW-1:0]  acc_i,
  input  blg_log_side_t           side_i,
  output logic                    valid_o,
  output logic [LossW-1:0]        loss_o,
  output logic signed [GradW-1:0] grad_o,
  output logic [HessW-1:0]        hess_o
);

  localparam logic signed [57:0] LossMax = 58'sd1099511627775;
  localparam logic signed [29:0] GradMax = 30'sd134217727;
  localparam logic signed [29:0] GradMin = -30'sd134217728;
  localparam logic [32:0]        HessMax = 33'd131071;

  logic               v1_q, v2_q;
  logic [39:0]        spn_q;
  logic [30:0]        p_q;
  logic [61:0]        h_q;
  logic signed [54:0] lin_q;
  logic [55:0]        sq_q;
  logic signed [26:0] label_q, pred_q;
  logic               mode_q;
  logic [LossW-1:0]   loss_q;
  logic signed [GradW-1:0] grad_q;
  logic [HessW-1:0]   hess_q;

  logic signed [26:0] zc;
  logic [37:0]        a;
  logic [33:0]        lg;
  logic [30:0]        qm;
  logic signed [27:0] fy;
  logic signed [27:0] d;
  logic [27:0]        dm;
  logic [39:0]        spn_d;
  logic [30:0]        p_d;

  always_comb begin
    zc    = clamp_z(side_i.base.pred, FRAC_BITS);
    a     = abs_q30(zc, FRAC_BITS);
    lg    = {acc_i[32:0], 1'b0};
    qm    = (31'd1 << 30) - side_i.ppos;
    spn_d = zc[26] ? (40'(a) + 40'(lg)) : 40'(lg);
    p_d   = zc[26] ? qm : side_i.ppos;
    fy    = (28'sd1 <<< FRAC_BITS) - 28'(side_i.base.label);
    d     = 28'(side_i.base.label) - 28'(side_i.base.pred);
    dm    = d[27] ? 28'(-d) : 28'(d);
  end

  logic [40:0]        lr;
  logic [54:0]        lmag;
  logic [55:0]        lm;
  logic signed [56:0] lsig;
  logic [31:0]        pr_r;
  logic [32:0]        hr;
  logic [56:0]        loss_s;
  logic signed [57:0] loss_w;
  logic signed [29:0] grad_w;
  logic [32:0]        hess_w;

  always_comb begin
    lr     = (41'(spn_q) + (41'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    lmag   = lin_q[54] ? 55'(-lin_q) : 55'(lin_q);
    lm     = (56'(lmag) + (56'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    lsig   = lin_q[54] ? -$signed({1'b0, lm}) : $signed({1'b0, lm});
    pr_r   = (32'(p_q) + (32'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    hr     = (33'(h_q[61:30]) + (33'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    loss_s = (57'(sq_q) + (57'd1 << FRAC_BITS)) >> (FRAC_BITS + 1);
    if (mode_q) begin
      loss_w = $signed({17'd0, lr}) + 58'(lsig);
      grad_w = $signed({1'b0, pr_r[28:0]}) - 30'(label_q);
      hess_w = hr;
    end else begin
      loss_w = $signed({1'b0, loss_s});
      grad_w = 30'(pred_q) - 30'(label_q);
      hess_w = 33'd1 << FRAC_BITS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    spn_q   <= spn_d;
    p_q     <= p_d;
    h_q     <= 62'(side_i.ppos) * 62'(qm);
    lin_q   <= 55'(fy) * 55'(zc);
    sq_q    <= 56'(dm) * 56'(dm);
    label_q <= side_i.base.label;
    pred_q  <= side_i.base.pred;
    mode_q  <= side_i.base.mode;
    if (loss_w < 58'sd0) begin
      loss_q <= '0;
    end else if (loss_w > LossMax) begin
      loss_q <= '1;
    end else begin
      loss_q <= loss_w[LossW-1:0];
    end
    if (grad_w > GradMax) begin
      grad_q <= GradMax[GradW-1:0];
    end else if (grad_w < GradMin) begin
      grad_q <= GradMin[GradW-1:0];
    end else begin
      grad_q <= grad_w[GradW-1:0];
    end
    if (hess_w > HessMax) begin
      hess_q <= HessMax[HessW-1:0];
    end else begin
      hess_q <= hess_w[HessW-1:0];
    end
  end

  assign valid_o = v2_q;
  assign loss_o  = loss_q;
  assign grad_o  = grad_q;
  assign hess_o  = hess_q;

endmodule

// ===== src/boosting_loss_grad_hess_unit.sv =====
// Top level of the boosting loss, gradient and hessian unit.
//
//   channel   direction  handshake            payload
//   sample    in         start (busy is 0)    label_i, prediction_i
//   result    out        valid_o strobe       loss_value_o, grad_value_o, hess_value_o
//   config    in         cfg_we_i             cfg_data_i (objective mode)
//
// A word is taken in every cycle; busy never rises. Each result passes through
// 3 front stages, 14 exponential series cells of 3 stages, one shift stage,
// 31 divider bit cells, one square stage, 12 logarithm cells of 3 stages and
// 2 output stages.
// Reset clears the valid bits of every stage and the mode register.
module boosting_loss_grad_hess_unit import blg_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    cfg_we_i,
  input  logic                    cfg_data_i,
  input  logic signed [InW-1:0]   label_i,
  input  logic signed [InW-1:0]   prediction_i,
  output logic                    valid_o,
  output logic [LossW-1:0]        loss_value_o,
  output logic signed [GradW-1:0] grad_value_o,
  output logic [HessW-1:0]        hess_value_o
);

  localparam int ExpSideW = $bits(blg_exp_side_t);
  localparam int BaseW    = $bits(blg_base_t);
  localparam int LogSideW = $bits(blg_log_side_t);

  logic      mode_q;
  blg_base_t in_base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_data_i;
    end
  end

  assign busy = 1'b0;

  always_comb begin
    in_base.mode  = mode_q;
    in_base.label = label_i;
    in_base.pred  = prediction_i;
  end

  logic        f_valid;
  blg_base_t   f_base;
  logic        f_zero;
  logic [5:0]  f_k;
  logic [29:0] f_r;

  blg_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .base_i  (in_base),
    .valid_o (f_valid),
    .base_o  (f_base),
    .zero_o  (f_zero),
    .k_o     (f_k),
    .r_o     (f_r)
  );

  // Exponential series: exp(-r) over the reduced argument.
  logic                   ev    [ExpTerms+1];
  logic [TermW-1:0]       eterm [ExpTerms+1];
  logic [OpW-1:0]         eop   [ExpTerms+1];
  logic signed [AccW-1:0] eacc  [ExpTerms+1];
  logic [ExpSideW-1:0]    eside [ExpTerms+1];
  blg_exp_side_t          eseed;

  always_comb begin
    eseed.zero = f_zero;
    eseed.k    = f_k;
    eseed.base = f_base;
  end

  assign ev[0]    = f_valid;
  assign eterm[0] = TermW'(1) << 30;
  assign eop[0]   = f_r;
  assign eacc[0]  = AccW'(1) << 30;
  assign eside[0] = eseed;

  for (genvar i = 0; i < ExpTerms; i++) begin : g_exp
    blg_series_cell #(
      .DIVISOR   (i + 1),
      .CHAIN_DIV (1'b1),
      .NEGATE    (((i + 1) % 2) == 1),
      .SIDE_W    (ExpSideW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (ev[i]),
      .term_i  (eterm[i]),
      .op_i    (eop[i]),
      .acc_i   (eacc[i]),
      .side_i  (eside[i]),
      .valid_o (ev[i+1]),
      .term_o  (eterm[i+1]),
      .op_o    (eop[i+1]),
      .acc_o   (eacc[i+1]),
      .side_o  (eside[i+1])
    );
  end

  // Scale by 2^-k and form e = exp(-|z|).
  blg_exp_side_t eout;
  logic [AccW-1:0] eacc_u;
  logic          e_v_q;
  logic [30:0]   e_q;
  blg_base_t     e_base_q;

  assign eout   = eside[ExpTerms];
  assign eacc_u = eacc[ExpTerms];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= 1'b0;
    end else begin
      e_v_q <= ev[ExpTerms];
    end
  end

  always_ff @(posedge clk_i) begin
    e_q      <= eout.zero ? 31'd0 : 31'(eacc_u >> eout.k);
    e_base_q <= eout.base;
  end

  // Divider chain: t = e/(2+e) and p = 1/(1+e), both in Q.30.
  logic          dv    [QuoW+1];
  blg_div_lane_t dla   [QuoW+1];
  blg_div_lane_t dlb   [QuoW+1];
  logic [BaseW-1:0] dside [QuoW+1];

  always_comb begin
    dla[0].rem = RemW'(e_q) << 30;
    dla[0].den = (DenW'(1) << 31) + DenW'(e_q);
    dla[0].quo = '0;
    dlb[0].rem = RemW'(1) << 60;
    dlb[0].den = (DenW'(1) << 30) + DenW'(e_q);
    dlb[0].quo = '0;
  end

  assign dv[0]    = e_v_q;
  assign dside[0] = e_base_q;

  for (genvar i = 0; i < QuoW; i++) begin : g_div
    blg_div_cell #(
      .J      (QuoW - 1 - i),
      .SIDE_W (BaseW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (dv[i]),
      .lane_a_i (dla[i]),
      .lane_b_i (dlb[i]),
      .side_i   (dside[i]),
      .valid_o  (dv[i+1]),
      .lane_a_o (dla[i+1]),
      .lane_b_o (dlb[i+1]),
      .side_o   (dside[i+1])
    );
  end

  logic             t_v_q;
  logic [TermW-1:0] t_q;
  logic [OpW-1:0]   t2_q;
  blg_log_side_t    t_side_q;
  logic [61:0]      tsq;

  assign tsq = 62'(dla[QuoW].quo) * 62'(dla[QuoW].quo);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_v_q <= 1'b0;
    end else begin
      t_v_q <= dv[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    t_q           <= dla[QuoW].quo;
    t2_q          <= tsq[59:30];
    t_side_q.ppos <= dlb[QuoW].quo;
    t_side_q.base <= dside[QuoW];
  end

  // Logarithm series: log1p(e)/2 = t + t^3/3 + t^5/5 + ...
  logic                   lv    [LogTerms+1];
  logic [TermW-1:0]       lterm [LogTerms+1];
  logic [OpW-1:0]         lop   [LogTerms+1];
  logic signed [AccW-1:0] lacc  [LogTerms+1];
  logic [LogSideW-1:0]    lside [LogTerms+1];

  assign lv[0]    = t_v_q;
  assign lterm[0] = t_q;
  assign lop[0]   = t2_q;
  assign lacc[0]  = $signed({2'b00, t_q});
  assign lside[0] = t_side_q;

  for (genvar i = 0; i < LogTerms; i++) begin : g_log
    blg_series_cell #(
      .DIVISOR   (2 * i + 3),
      .CHAIN_DIV (1'b0),
      .NEGATE    (1'b0),
      .SIDE_W    (LogSideW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (lv[i]),
      .term_i  (lterm[i]),
      .op_i    (lop[i]),
      .acc_i   (lacc[i]),
      .side_i  (lside[i]),
      .valid_o (lv[i+1]),
      .term_o  (lterm[i+1]),
      .op_o    (lop[i+1]),
      .acc_o   (lacc[i+1]),
      .side_o  (lside[i+1])
    );
  end

  // The last cells' terms and operands and the divider remainders and denominators are not needed past the chains.
  blg_log_side_t lout;
  logic          log_tail_unused;

  assign lout            = lside[LogTerms];
  assign log_tail_unused = ^{lterm[LogTerms], lop[LogTerms], eterm[ExpTerms], eop[ExpTerms],
                             dla[QuoW].rem, dla[QuoW].den, dlb[QuoW].rem, dlb[QuoW].den};

  blg_finish #(.FRAC_BITS(FRAC_BITS)) u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (lv[LogTerms]),
    .acc_i   (lacc[LogTerms]),
    .side_i  (lout),
    .valid_o (valid_o),
    .loss_o  (loss_value_o),
    .grad_o  (grad_value_o),
    .hess_o  (hess_value_o)
  );

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench of the boosting loss, gradient and hessian unit.
module testbench import blg_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic {ModeSquared = 1'b0, ModeLogistic = 1'b1} obj_mode_e;

  typedef struct packed {
    logic [LossW-1:0]        loss;
    logic signed [GradW-1:0] grad;
    logic [HessW-1:0]        hess;
  } grad_word_t;

  typedef struct {
    obj_mode_e               mode;
    logic signed [InW-1:0]   label;
    logic signed [InW-1:0]   pred;
    logic                    typed;
    grad_word_t              word;
  } stim_row_t;

  localparam int  Frac      = FracBitsDef;
  localparam longint One30  = 64'sd1 <<< 30;
  localparam longint Ln2    = 64'sd744261118;
  localparam longint OneQ   = 64'sd1 <<< Frac;
  localparam longint ZLim   = 64'sd250 <<< Frac;
  localparam int  Latency   = 116;
  localparam int  StallLim  = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cfg_we_i = 1'b0;
  logic cfg_data_i = 1'b0;
  logic signed [InW-1:0] label_i = '0;
  logic signed [InW-1:0] prediction_i = '0;
  logic valid_o;
  logic [LossW-1:0] loss_value_o;
  logic signed [GradW-1:0] grad_value_o;
  logic [HessW-1:0] hess_value_o;

  // Typed expectation travelling with the word on the bus.
  logic       typed_q = 1'b0;
  grad_word_t typed_word_q = '0;

  obj_mode_e  mode_model = ModeSquared;
  grad_word_t pending_words[$];
  int         errors = 0;
  int         words_in = 0;
  int         words_out = 0;
  int         idle_cycles = 0;
  int         gap_pct = 0;
  stim_row_t  rows[$];

  boosting_loss_grad_hess_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i),
    .label_i(label_i), .prediction_i(prediction_i),
    .valid_o(valid_o), .loss_value_o(loss_value_o),
    .grad_value_o(grad_value_o), .hess_value_o(hess_value_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint round_shift(longint v, int s);
    longint half;
    half = 64'sd1 <<< (s - 1);
    if (v >= 0) begin
      return (v + half) >>> s;
    end
    return -((-v + half) >>> s);
  endfunction

  // exp(-a) for a >= 0, both in Q.30.
  function automatic longint exp_neg(longint a);
    longint k, r, term, sum;
    k = a / Ln2;
    r = a - k * Ln2;
    term = One30;
    sum = One30;
    if (k >= 40) begin
      return 0;
    end
    for (int n = 1; n <= 14; n++) begin
      term = ((term * r) >>> 30) / n;
      if (n % 2 == 1) begin
        sum -= term;
      end else begin
        sum += term;
      end
    end
    return sum >>> k;
  endfunction

  // log(1+x) for x in [0,1], Q.30.
  function automatic longint log_one_plus(longint x);
    longint t, t2, term, sum;
    t = (x <<< 30) / (2 * One30 + x);
    t2 = (t * t) >>> 30;
    term = t;
    sum = t;
    for (int k = 3; k <= 25; k += 2) begin
      term = (term * t2) >>> 30;
      sum += term / k;
    end
    return 2 * sum;
  endfunction

  function automatic grad_word_t loss_grad_hess(obj_mode_e mode, longint y, longint pr);
    longint loss, grad, hess, d, zc, a, e, lg, ppos, p, spn, h30, lin;
    grad_word_t w;
    if (mode == ModeSquared) begin
      d = y - pr;
      loss = (d * d + OneQ) >>> (Frac + 1);
      grad = pr - y;
      hess = OneQ;
    end else begin
      zc = clip(pr, -ZLim, ZLim);
      a = (zc < 0 ? -zc : zc) <<< (30 - Frac);
      e = exp_neg(a);
      lg = log_one_plus(e);
      ppos = (One30 <<< 30) / (One30 + e);
      p = zc >= 0 ? ppos : One30 - ppos;
      spn = zc >= 0 ? lg : a + lg;
      h30 = (ppos * (One30 - ppos)) >>> 30;
      lin = (OneQ - y) * zc;
      loss = round_shift(spn, 30 - Frac) + round_shift(lin, Frac);
      grad = round_shift(p, 30 - Frac) - y;
      hess = round_shift(h30, 30 - Frac);
    end
    w.loss = LossW'(clip(loss, 0, (64'sd1 <<< 40) - 1));
    w.grad = GradW'(clip(grad, -(64'sd1 <<< 27), (64'sd1 <<< 27) - 1));
    w.hess = HessW'(clip(hess, 0, (64'sd1 <<< 17) - 1));
    return w;
  endfunction

  task automatic report(string what, grad_word_t got, grad_word_t want);
    errors++;
    $display("MISMATCH %s: got loss=%0d grad=%0d hess=%0d, want loss=%0d grad=%0d hess=%0d",
             what, got.loss, got.grad, got.hess, want.loss, want.grad, want.hess);
  endtask

  // Acceptance side: every word taken is turned into its expected result.
  always @(posedge clk_i) begin
    grad_word_t w;
    if (rst_ni && start && !busy) begin
      w = loss_grad_hess(mode_model, label_i, prediction_i);
      if (typed_q && w != typed_word_q) begin
        report("typed row vs predictor", w, typed_word_q);
      end
      pending_words.push_back(typed_q ? typed_word_q : w);
      words_in++;
    end
  end

  always @(posedge clk_i) begin
    grad_word_t got, want;
    if (rst_ni && valid_o) begin
      got = '{loss_value_o, grad_value_o, hess_value_o};
      words_out++;
      if (pending_words.size() == 0) begin
        report("result word with nothing expected", got, '0);
      end else begin
        want = pending_words.pop_front();
        if (got.loss != want.loss) report("loss", got, want);
        if (got.grad != want.grad) report("grad", got, want);
        if (got.hess != want.hess) report("hess", got, want);
      end
    end
  end

  // Watchdog on cycles in which no word moves either way.
  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLim) begin
      $display("watchdog expired with %0d results outstanding", pending_words.size());
      $display("boosting_loss_grad_hess_unit verification failed");
      $finish;
    end
  end

  task automatic send_word(logic signed [InW-1:0] y, logic signed [InW-1:0] pr,
                           logic typed, grad_word_t w);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start <= 1'b1;
    label_i <= y;
    prediction_i <= pr;
    typed_q <= typed;
    typed_word_q <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Lets the pipeline empty, then writes the objective mode.
  task automatic set_mode(obj_mode_e m);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (Latency + 8) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mode_model = m;
  endtask

  task automatic add_row(obj_mode_e m, longint y, longint pr, logic typed,
                         longint l, longint g, longint h);
    stim_row_t r;
    r.mode = m;
    r.label = InW'(y);
    r.pred = InW'(pr);
    r.typed = typed;
    r.word = '{LossW'(l), GradW'(g), HessW'(h)};
    rows.push_back(r);
  endtask

  function automatic logic signed [InW-1:0] rand_value(bit is_label, obj_mode_e m);
    case ($urandom_range(4))
      0: return InW'($urandom);
      1: return InW'(int'($urandom_range(0, 2 * 8 * OneQ)) - 8 * OneQ);
      2: return $urandom_range(1) ? InW'(64'sd1 <<< 26) : InW'((64'sd1 <<< 26) - 1);
      default: begin
        if (is_label && m == ModeLogistic) begin
          return $urandom_range(1) ? InW'(OneQ) : '0;
        end
        return InW'(int'($urandom_range(0, 2 * 300 * OneQ)) - 300 * OneQ);
      end
    endcase
  endfunction

  initial begin
    longint mx, mn;
    obj_mode_e m;
    mx = (64'sd1 <<< 26) - 1;
    mn = -(64'sd1 <<< 26);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows: squared mode first (mode is squared after reset).
    add_row(ModeSquared, 0, 0, 1, 0, 0, OneQ);
    add_row(ModeSquared, 0, OneQ, 1, OneQ / 2, OneQ, OneQ);
    add_row(ModeSquared, OneQ, 0, 1, OneQ / 2, -OneQ, OneQ);
    add_row(ModeSquared, mn, mx, 1, (64'sd1 <<< 37) - (64'sd1 <<< 11),
            (64'sd1 <<< 27) - 1, OneQ);
    add_row(ModeSquared, mx, mn, 0, 0, 0, 0);
    add_row(ModeSquared, mx, mx, 1, 0, 0, OneQ);
    add_row(ModeSquared, mn, 0, 0, 0, 0, 0);
    add_row(ModeSquared, 1, -1, 0, 0, 0, 0);
    add_row(ModeLogistic, 0, 0, 0, 0, 0, 0);
    add_row(ModeLogistic, OneQ, 0, 0, 0, 0, 0);
    add_row(ModeLogistic, 0, 250 * OneQ, 0, 0, 0, 0);
    add_row(ModeLogistic, 0, mx, 0, 0, 0, 0);
    add_row(ModeLogistic, OneQ, mn, 0, 0, 0, 0);
    add_row(ModeLogistic, 0, -250 * OneQ, 0, 0, 0, 0);
    add_row(ModeLogistic, 5 * OneQ, 100 * OneQ, 1, 0, OneQ - 5 * OneQ, 0);
    add_row(ModeLogistic, mn, mx, 0, 0, 0, 0);
    add_row(ModeLogistic, mx, mn, 0, 0, 0, 0);
    add_row(ModeLogistic, OneQ / 2, 3 * OneQ, 0, 0, 0, 0);
    add_row(ModeLogistic, 0, 1, 0, 0, 0, 0);
    add_row(ModeLogistic, 0, 30 * OneQ, 0, 0, 0, 0);
    foreach (rows[i]) begin
      if (rows[i].mode != mode_model) set_mode(rows[i].mode);
      send_word(rows[i].label, rows[i].pred, rows[i].typed, rows[i].word);
    end

    // Random part in three idling profiles, mode flipped between chunks.
    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = ph == 0 ? 24 : (ph == 1 ? 86 : 0);
      for (int chunk = 0; chunk < 4; chunk++) begin
        m = obj_mode_e'(chunk % 2 == 0 ? ModeLogistic : ModeSquared);
        if (m != mode_model) set_mode(m);
        repeat (145) begin
          send_word(rand_value(1, m), rand_value(0, m), 1'b0, '0);
        end
      end
    end
    start <= 1'b0;

    @(posedge clk_i);
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (Latency + 20) @(posedge clk_i);
    $display("Covered %0d samples in both objectives, with field extremes, clamped margins",
             words_in);
    $display("and three sender idling profiles; %0d results checked.", words_out);
    if (errors == 0) begin
      $display("boosting_loss_grad_hess_unit verification clean");
    end else begin
      $display("boosting_loss_grad_hess_unit verification failed");
    end
    $finish;
  end

endmodule
